// ----- hw/rtl/assert_macros.svh -----
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TPP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge.
`define TPP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/tpp_pkg.sv -----
package tpp_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;
    localparam int QUO_W  = 41;   // clamped quotient, range -2^40 .. 2^40-1
    localparam int DIV_N  = 41;   // quotient bits produced serially
    localparam int DIV_CW = 6;

    // quotient clamp limits
    localparam logic signed [QUO_W-1:0] QUO_MAX = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic signed [QUO_W-1:0] QUO_MIN = {1'b1, {(QUO_W-1){1'b0}}};

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
    } t_vert;

    typedef enum logic [2:0] {
        K_WHOLE = 3'd0,
        K_TWO0  = 3'd1,
        K_TWO1  = 3'd2,
        K_TWO2  = 3'd3,
        K_THREE = 3'd4
    } t_kind;

    // Classified triangle handed from front to back.
    typedef struct packed {
        t_kind             kind;
        logic              side;      // side of first piece
        logic [1:0]        cp;        // cut start vertex (lone vertex of a three-piece split)
        logic [1:0]        cq0;       // end vertex of first cut
        logic [1:0]        cq1;       // end vertex of second cut
        logic              two_cuts;
        t_vert [2:0]       v;
        logic [2:0][31:0]  d;
    } t_entry;

    typedef struct packed {
        t_word       nx;
        t_word       ny;
        t_word       nz;
        t_word       off;
        logic [15:0] band;
    } t_cfg;

    localparam logic [2:0] CFG_NX   = 3'd0;
    localparam logic [2:0] CFG_NY   = 3'd1;
    localparam logic [2:0] CFG_NZ   = 3'd2;
    localparam logic [2:0] CFG_OFF  = 3'd3;
    localparam logic [2:0] CFG_BAND = 3'd4;

    localparam logic signed [50:0] SAT_HI = 51'sd2147483647;
    localparam logic signed [50:0] SAT_LO = -51'sd2147483648;

    function automatic t_word sat32(input logic signed [50:0] x);
        t_word r;
        if (x > SAT_HI) begin
            r = 32'sh7fffffff;
        end else if (x < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = t_word'(x);
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/tpp_front.sv -----
module tpp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpp_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [383:0]      i_data,
    output logic              o_push,
    output tpp_pkg::t_entry   o_entry,
    input  logic              i_full
);

    logic signed [31:0] vin [3][3];
    logic signed [31:0] fn  [3];
    logic signed [31:0] pn  [3];
    logic signed [63:0] n_pv [3][3];
    logic signed [63:0] n_pf [3];
    logic signed [63:0] r_pv [3][3];
    logic signed [63:0] r_pf [3];
    logic signed [31:0] r_vt1 [3][3];
    logic signed [31:0] r_vt2 [3][3];
    logic signed [31:0] n_d [3];
    logic signed [31:0] r_d [3];
    logic               n_face;
    logic               r_face;
    logic               r_v1;
    logic               r_v2;
    logic               en;

    assign en      = !r_v2 || !i_full;
    assign o_ready = en;
    assign o_push  = r_v2 && !i_full;

    assign pn[0] = i_cfg.nx;
    assign pn[1] = i_cfg.ny;
    assign pn[2] = i_cfg.nz;

    // stage 1: products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                vin[i][j]  = $signed(i_data[(i*3+j)*32 +: 32]);
                n_pv[i][j] = 64'(pn[j]) * 64'(vin[i][j]);
            end
            fn[i]   = $signed(i_data[288 + i*32 +: 32]);
            n_pf[i] = 64'(pn[i]) * 64'(fn[i]);
        end
    end

    // stage 2: floor-shifted sums, offset, saturation, face sign
    always_comb begin
        logic signed [50:0] acc;
        logic signed [50:0] fa;
        for (int i = 0; i < 3; i++) begin
            acc = 51'(r_pv[i][0] >>> 16) + 51'(r_pv[i][1] >>> 16)
                + 51'(r_pv[i][2] >>> 16) - 51'(i_cfg.off);
            n_d[i] = tpp_pkg::sat32(acc);
        end
        fa = 51'(r_pf[0] >>> 16) + 51'(r_pf[1] >>> 16) + 51'(r_pf[2] >>> 16);
        n_face = (fa > 51'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (en) begin
            r_pv   <= n_pv;
            r_pf   <= n_pf;
            r_vt1  <= vin;
            r_vt2  <= r_vt1;
            r_d    <= n_d;
            r_face <= n_face;
        end
    end

    // classification against the band
    always_comb begin
        logic signed [33:0] dd [3];
        logic signed [33:0] ad;
        logic signed [33:0] eps;
        logic [2:0] on_b;
        logic [2:0] gt;
        logic [2:0] lt;
        logic [1:0] lone;
        logic       ps;
        eps = $signed({18'd0, i_cfg.band});
        for (int i = 0; i < 3; i++) begin
            dd[i]   = 34'(r_d[i]);
            ad      = (dd[i] < 34'sd0) ? -dd[i] : dd[i];
            on_b[i] = ad < eps;
            gt[i]   = dd[i] > -eps;
            lt[i]   = dd[i] < eps;
        end
        for (int i = 0; i < 3; i++) begin
            o_entry.v[i].x = r_vt2[i][0];
            o_entry.v[i].y = r_vt2[i][1];
            o_entry.v[i].z = r_vt2[i][2];
            o_entry.d[i]   = r_d[i];
        end
        o_entry.kind     = tpp_pkg::K_WHOLE;
        o_entry.side     = 1'b0;
        o_entry.cp       = 2'd0;
        o_entry.cq0      = 2'd0;
        o_entry.cq1      = 2'd0;
        o_entry.two_cuts = 1'b0;
        lone = 2'd0;
        ps   = 1'b0;
        priority if (&on_b) begin
            o_entry.side = ~r_face;
        end else if (&gt) begin
            o_entry.side = 1'b0;
        end else if (&lt) begin
            o_entry.side = 1'b1;
        end else if (on_b[0]) begin
            o_entry.kind = tpp_pkg::K_TWO0;
            o_entry.side = !(dd[1] > 34'sd0);
            o_entry.cp   = 2'd1;
            o_entry.cq0  = 2'd2;
        end else if (on_b[1]) begin
            o_entry.kind = tpp_pkg::K_TWO1;
            o_entry.side = !(dd[0] > 34'sd0);
            o_entry.cp   = 2'd0;
            o_entry.cq0  = 2'd2;
        end else if (on_b[2]) begin
            o_entry.kind = tpp_pkg::K_TWO2;
            o_entry.side = !(dd[0] > 34'sd0);
            o_entry.cp   = 2'd0;
            o_entry.cq0  = 2'd1;
        end else begin
            if (gt[0]) begin
                priority if (gt[1]) begin
                    lone = 2'd2; ps = 1'b0;
                end else if (gt[2]) begin
                    lone = 2'd1; ps = 1'b0;
                end else begin
                    lone = 2'd0; ps = 1'b1;
                end
            end else begin
                priority if (lt[1]) begin
                    lone = 2'd2; ps = 1'b1;
                end else if (lt[2]) begin
                    lone = 2'd1; ps = 1'b1;
                end else begin
                    lone = 2'd0; ps = 1'b0;
                end
            end
            o_entry.kind     = tpp_pkg::K_THREE;
            o_entry.side     = ps;
            o_entry.cp       = lone;
            o_entry.two_cuts = 1'b1;
            unique case (lone)
                2'd0: begin
                    o_entry.cq0 = 2'd1; o_entry.cq1 = 2'd2;
                end
                2'd1: begin
                    o_entry.cq0 = 2'd2; o_entry.cq1 = 2'd0;
                end
                default: begin
                    o_entry.cq0 = 2'd0; o_entry.cq1 = 2'd1;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/tpp_fifo.sv -----
`include "assert_macros.svh"

module tpp_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tpp_pkg::t_entry   i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output tpp_pkg::t_entry   o_entry,
    output logic              o_empty
);

    tpp_pkg::t_entry               r_mem [tpp_pkg::QDEPTH];
    logic [tpp_pkg::QAW-1:0]       r_wp;
    logic [tpp_pkg::QAW-1:0]       r_rp;
    logic [tpp_pkg::QCW-1:0]       r_cnt;

    assign o_full  = (r_cnt == tpp_pkg::QCW'(tpp_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    `TPP_ASSERT(a_no_overflow, o_full |-> !i_push, "push into full queue")
    `TPP_ASSERT(a_no_underflow, o_empty |-> !i_pop, "pop from empty queue")

endmodule

// ----- hw/rtl/tpp_div.sv -----
module tpp_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [64:0]                i_num,
    input  logic signed [32:0]                i_den,
    output logic                              o_busy,
    output logic signed [tpp_pkg::QUO_W-1:0]  o_quo
);

    logic                              r_busy;
    logic [tpp_pkg::DIV_CW-1:0]        r_cnt;
    logic [32:0]                       r_rem;
    logic [32:0]                       r_dm;
    logic [tpp_pkg::DIV_N-1:0]         r_sh;
    logic [tpp_pkg::DIV_N-1:0]         r_mag;
    logic                              r_neg;
    logic signed [tpp_pkg::QUO_W-1:0]  r_q;

    logic [64:0] nm;
    logic [32:0] dm;
    logic        ovf;
    logic [33:0] t;
    logic        bit_q;
    logic [33:0] t_sub;
    logic [tpp_pkg::DIV_N-1:0] n_mag;

    assign o_busy = r_busy;
    assign o_quo  = r_q;

    always_comb begin
        nm    = i_num[64] ? 65'(-i_num) : 65'(i_num);
        dm    = i_den[32] ? 33'(-i_den) : 33'(i_den);
        ovf   = {9'd0, nm} >= {dm, 41'd0};
        t     = {r_rem, r_sh[tpp_pkg::DIV_N-1]};
        bit_q = t >= {1'b0, r_dm};
        t_sub = t - {1'b0, r_dm};
        n_mag = {r_mag[tpp_pkg::DIV_N-2:0], bit_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_neg <= i_num[64] ^ i_den[32];
            r_dm  <= dm;
            r_rem <= 33'(nm[64:tpp_pkg::DIV_N]);
            r_sh  <= nm[tpp_pkg::DIV_N-1:0];
            r_mag <= '0;
            r_cnt <= tpp_pkg::DIV_CW'(tpp_pkg::DIV_N);
            if (dm == '0) begin
                r_q    <= '0;
                r_busy <= 1'b0;
            end else if (ovf) begin
                r_q    <= (i_num[64] ^ i_den[32]) ? tpp_pkg::QUO_MIN : tpp_pkg::QUO_MAX;
                r_busy <= 1'b0;
            end else begin
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            r_rem <= bit_q ? t_sub[32:0] : t[32:0];
            r_sh  <= {r_sh[tpp_pkg::DIV_N-2:0], 1'b0};
            r_mag <= n_mag;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == tpp_pkg::DIV_CW'(1)) begin
                r_busy <= 1'b0;
                // top bit set means |q| >= 2^40: clamp
                if (n_mag[tpp_pkg::DIV_N-1]) begin
                    r_q <= r_neg ? tpp_pkg::QUO_MIN : tpp_pkg::QUO_MAX;
                end else begin
                    r_q <= r_neg ? -$signed(n_mag) : $signed(n_mag);
                end
            end
        end
    end

endmodule

// ----- hw/rtl/tpp_back.sv -----
`include "assert_macros.svh"

module tpp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  tpp_pkg::t_entry   i_entry,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [287:0]      o_data,
    output logic              o_side,
    output logic              o_last
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                r_st, n_st;
    tpp_pkg::t_entry       r_e, n_e;
    tpp_pkg::t_vert        r_n [2];
    logic                  r_ci, n_ci;
    logic [1:0]            r_pc, n_pc;
    logic signed [64:0]    r_num [3];
    logic signed [32:0]    r_den;
    logic signed [31:0]    r_p [3];
    logic                  r_ov;
    logic [287:0]          r_od;
    logic                  r_side;
    logic                  r_last;

    logic signed [tpp_pkg::QUO_W-1:0] quo [3];
    logic [2:0]            busy;
    logic                  start;
    logic                  out_free;
    logic                  load;
    logic                  cut_done;

    tpp_pkg::t_vert        pv, qv;
    logic signed [31:0]    dp, dq;
    logic signed [31:0]    pc3 [3];
    logic signed [31:0]    qc3 [3];
    tpp_pkg::t_vert        src [5];
    logic [2:0]            sa, sb, sc;
    logic                  pside, plast;
    tpp_pkg::t_vert        cut_v;

    function automatic tpp_pkg::t_vert vsel(input tpp_pkg::t_vert [2:0] v,
                                           input logic [1:0] i);
        tpp_pkg::t_vert r;
        unique case (i)
            2'd1:    r = v[1];
            2'd2:    r = v[2];
            default: r = v[0];
        endcase
        return r;
    endfunction

    function automatic tpp_pkg::t_vert ssel(input tpp_pkg::t_vert s [5],
                                           input logic [2:0] i);
        tpp_pkg::t_vert r;
        unique case (i)
            3'd1:    r = s[1];
            3'd2:    r = s[2];
            3'd3:    r = s[3];
            3'd4:    r = s[4];
            default: r = s[0];
        endcase
        return r;
    endfunction

    assign out_free = !r_ov || i_ready;
    assign cut_done = (busy == 3'b000);

    // cut operands
    always_comb begin
        logic [1:0] qi;
        qi = r_ci ? r_e.cq1 : r_e.cq0;
        pv = vsel(r_e.v, r_e.cp);
        qv = vsel(r_e.v, qi);
        dp = $signed(r_e.d[r_e.cp]);
        dq = $signed(r_e.d[qi]);
        pc3[0] = pv.x; pc3[1] = pv.y; pc3[2] = pv.z;
        qc3[0] = qv.x; qc3[1] = qv.y; qc3[2] = qv.z;
        cut_v.x = tpp_pkg::sat32(51'(r_p[0]) + 51'(quo[0]));
        cut_v.y = tpp_pkg::sat32(51'(r_p[1]) + 51'(quo[1]));
        cut_v.z = tpp_pkg::sat32(51'(r_p[2]) + 51'(quo[2]));
    end

    // piece layout: sources 0..2 are vertices, 3 first cut, 4 second cut
    always_comb begin
        src[0] = r_e.v[0];
        src[1] = r_e.v[1];
        src[2] = r_e.v[2];
        src[3] = r_n[0];
        src[4] = r_n[1];
        sa = 3'd0; sb = 3'd1; sc = 3'd2;
        pside = r_e.side;
        plast = 1'b1;
        unique case (r_e.kind)
            tpp_pkg::K_TWO0: begin
                plast = r_pc[0];
                if (!r_pc[0]) begin
                    sa = 3'd0; sb = 3'd1; sc = 3'd3;
                end else begin
                    sa = 3'd0; sb = 3'd3; sc = 3'd2; pside = ~r_e.side;
                end
            end
            tpp_pkg::K_TWO1: begin
                plast = r_pc[0];
                if (!r_pc[0]) begin
                    sa = 3'd0; sb = 3'd1; sc = 3'd3;
                end else begin
                    sa = 3'd1; sb = 3'd2; sc = 3'd3; pside = ~r_e.side;
                end
            end
            tpp_pkg::K_TWO2: begin
                plast = r_pc[0];
                if (!r_pc[0]) begin
                    sa = 3'd0; sb = 3'd3; sc = 3'd2;
                end else begin
                    sa = 3'd3; sb = 3'd1; sc = 3'd2; pside = ~r_e.side;
                end
            end
            tpp_pkg::K_THREE: begin
                plast = (r_pc == 2'd2);
                priority if (r_pc == 2'd0) begin
                    sa = {1'b0, r_e.cq0}; sb = {1'b0, r_e.cq1}; sc = 3'd4;
                end else if (r_pc == 2'd1) begin
                    sa = {1'b0, r_e.cq0}; sb = 3'd4; sc = 3'd3;
                end else begin
                    sa = 3'd3; sb = 3'd4; sc = {1'b0, r_e.cp}; pside = ~r_e.side;
                end
            end
            default: begin
                plast = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_st  = r_st;
        n_e   = r_e;
        n_ci  = r_ci;
        n_pc  = r_pc;
        o_pop = 1'b0;
        start = 1'b0;
        load  = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_e   = i_entry;
                    n_ci  = 1'b0;
                    n_pc  = 2'd0;
                    n_st  = (i_entry.kind == tpp_pkg::K_WHOLE) ? S_EMIT : S_MUL;
                end
            end
            S_MUL: begin
                n_st = S_START;
            end
            S_START: begin
                start = 1'b1;
                n_st  = S_DIV;
            end
            S_DIV: begin
                if (cut_done) begin
                    if (!r_ci && r_e.two_cuts) begin
                        n_ci = 1'b1;
                        n_st = S_MUL;
                    end else begin
                        n_st = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load = 1'b1;
                    n_pc = r_pc + 1'b1;
                    if (plast) n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        tpp_pkg::t_vert a, b, c;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
        r_e  <= n_e;
        r_ci <= n_ci;
        r_pc <= n_pc;
        if (r_st == S_MUL) begin
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= 65'(33'(qc3[k]) - 33'(pc3[k])) * 65'(dp);
                r_p[k]   <= pc3[k];
            end
            r_den <= 33'(dp) - 33'(dq);
        end
        if (r_st == S_DIV && cut_done) begin
            r_n[r_ci] <= cut_v;
        end
        if (load) begin
            a = ssel(src, sa);
            b = ssel(src, sb);
            c = ssel(src, sc);
            r_od   <= {c.z, c.y, c.x, b.z, b.y, b.x, a.z, a.y, a.x};
            r_side <= pside;
            r_last <= plast;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        tpp_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (start),
            .i_num   (r_num[g]),
            .i_den   (r_den),
            .o_busy  (busy[g]),
            .o_quo   (quo[g])
        );
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;
    assign o_side  = r_side;
    assign o_last  = r_last;

    `TPP_ASSERT(a_pop_idle, o_pop |-> (r_st == S_IDLE), "queue pop outside idle")
    `TPP_ASSERT(a_start_div, (r_st == S_START) |=> (r_st == S_DIV), "divide not started")
    `TPP_ASSERT(a_load_emit, load |-> (r_st == S_EMIT) && out_free, "output load out of turn")

endmodule

// ----- hw/rtl/triangle_plane_partition.sv -----
// Channel  Dir  Transaction                   Payload
// s_axis   in   one triangle                  tdata: a_x..c_z, face_nx..face_nz (384 b)
// m_axis   out  one output triangle (1..3/in) tdata: out_a_x..out_c_z, tuser: side,
//                                             tlast: final_piece
// cfg      in   register write, no wait       i_cfg_idx selects, i_cfg_data 32 b
//
// Front: 3-stage pipeline (multiply, sum/saturate, classify) takes one triangle
// per cycle, while the queue is not full, into a 4-entry queue. Back: a triangle
// wholly on one side is dequeued, then each output piece is emitted when the
// output is free. Each edge cut runs a setup (products in S_MUL, divider start in
// S_START), then the bit-serial dividers (41 quotient bits, three in parallel,
// one per coordinate; a zero or overflowing divide does not iterate). A two-piece
// split makes one cut and a three-piece split two, before its pieces are emitted.
// Reset is synchronous, active low; config registers take their defaults.
// Output back pressure fills the queue, then drops s_axis_tready.
module triangle_plane_partition (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config write
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    // input triangles
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [383:0]  s_axis_tdata,   // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z,face_nx,face_ny,face_nz
    // output triangles
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [287:0]  m_axis_tdata,   // out_a_x,out_a_y,out_a_z,out_b_x..out_b_z,out_c_x..out_c_z
    output logic [0:0]    m_axis_tuser,   // side (0 front, 1 back)
    output logic          m_axis_tlast    // final_piece
);

    tpp_pkg::t_cfg    r_cfg;
    tpp_pkg::t_entry  f_entry;
    tpp_pkg::t_entry  q_entry;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    logic             side;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nx   <= 32'sd0;
            r_cfg.ny   <= 32'sd0;
            r_cfg.nz   <= 32'sd65536;   // 1.0
            r_cfg.off  <= 32'sd0;
            r_cfg.band <= 16'd7;        // ~0.0001
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tpp_pkg::CFG_NX:   r_cfg.nx   <= $signed(i_cfg_data);
                tpp_pkg::CFG_NY:   r_cfg.ny   <= $signed(i_cfg_data);
                tpp_pkg::CFG_NZ:   r_cfg.nz   <= $signed(i_cfg_data);
                tpp_pkg::CFG_OFF:  r_cfg.off  <= $signed(i_cfg_data);
                tpp_pkg::CFG_BAND: r_cfg.band <= i_cfg_data[15:0];
                default:           r_cfg      <= r_cfg;
            endcase
        end
    end

    // classify
    tpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_push  (push),
        .o_entry (f_entry),
        .i_full  (full)
    );

    // decouples classification from cutting
    tpp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_empty (empty)
    );

    // cut and emit pieces
    tpp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (q_entry),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_side  (side),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tuser = side;

endmodule
